// File: src/tdfsm_pkg.sv
// Shared types and codes of the table-driven state machine engine.
// No dependencies; the engine and its RAM take what they need from here.
package tdfsm_pkg;

	localparam int STATE_W = 6;

	typedef enum logic [1:0] {
		OP_DELIVER = 2'd0,
		OP_WRITE   = 2'd1,
		OP_RESET   = 2'd2,
		OP_RETURN  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_EXIT   = 2'd0,
		KIND_TRANS  = 2'd1,
		KIND_ENTRY  = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_ARGS = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_BAD_NXT = 2'd3
	} status_t;

	typedef enum logic {
		CFG_INITIAL = 1'b0,
		CFG_COUNT   = 1'b1
	} cfg_idx_t;

	localparam logic [7:0] EV_NULL    = 8'd0;
	localparam logic [7:0] EV_ENTRY   = 8'd1;
	localparam logic [7:0] EV_EXIT    = 8'd2;
	localparam logic [7:0] EV_DEFAULT = 8'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_EMIT_EXIT,
		S_EMIT_TRANS,
		S_EMIT_ENTRY,
		S_EMIT_STAT
	} seq_t;

	typedef enum logic [1:0] {
		PH_EXT,
		PH_CUR,
		PH_NEW
	} phase_t;

endpackage

// File: src/tdfsm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing but tdfsm_pkg, which it imports.
module tdfsm_ram
	import tdfsm_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/table_driven_fsm_engine_top.sv
// Table-driven state machine engine: slot tables in two RAMs and a scan sequencer.
// Depends on tdfsm_pkg and tdfsm_ram.
// Slot write, reset and return go straight to the status result, which raises out_valid
// once the output register is free. An event walks the extension list, the current
// state's list and, on a move, the new state's list, one slot per cycle through the RAM
// read port. After reset a clearing pass blanks the tables before in_ready rises.
module table_driven_fsm_engine_top
	import tdfsm_pkg::*;
#(
	parameter int MAX_STATES      = 64,
	parameter int SLOTS_PER_STATE = 16,
	parameter int EXT_SLOTS       = 16,
	parameter int EVENT_BITS      = 8,
	parameter int ACTION_BITS     = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] event_code,
	input  logic       wants_args,
	input  logic       has_args,
	input  logic       table_select,
	input  logic [5:0] slot_state,
	input  logic [3:0] slot_index,
	input  logic [7:0] slot_event,
	input  logic [5:0] slot_next,
	input  logic       slot_stay,
	input  logic [7:0] slot_action,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] result_kind,
	output logic [7:0] action_id,
	output logic [1:0] status,
	output logic [5:0] current_after,
	output logic       last,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);

	localparam int SDEPTH = MAX_STATES * SLOTS_PER_STATE;
	localparam int SAW    = $clog2(SDEPTH);
	localparam int EAW    = EXT_SLOTS > 1 ? $clog2(EXT_SLOTS) : 1;
	localparam int SW     = EVENT_BITS + STATE_W + 1 + ACTION_BITS;
	localparam int LMAX   = SLOTS_PER_STATE > EXT_SLOTS ? SLOTS_PER_STATE : EXT_SLOTS;
	localparam int IW     = $clog2(LMAX + 1);
	localparam int CLR_N  = SDEPTH > EXT_SLOTS ? SDEPTH : EXT_SLOTS;
	localparam int CW     = $clog2(CLR_N);

	seq_t   st_q, st_d;
	phase_t ph_q;

	logic [STATE_W-1:0] init_q, cur_q, prev_q, scan_st_q;
	logic [6:0]         count_q;
	logic [CW-1:0]      clr_q;
	logic [IW-1:0]      idx_q, len;
	logic               pend_q;
	logic [EVENT_BITS-1:0] ev_q;
	status_t            stat_q;
	logic               move_q;

	// Candidate slots gathered during the scans.
	logic [SW-1:0]          xh_q, xd_q, ch_q, cd_q;
	logic                   xh_v_q, xd_v_q, ch_v_q, cd_v_q;
	logic [ACTION_BITS-1:0] xx_q, xn_q, cx_q, nn_q;
	logic                   xx_v_q, xn_v_q, cx_v_q, nn_v_q;
	logic [STATE_W-1:0]     tk_next_q;
	logic [ACTION_BITS-1:0] tk_act_q;

	// Output register.
	logic                   ov_q, olast_q;
	kind_t                  okind_q;
	logic [7:0]             oact_q;
	status_t                ostat_q;
	logic [STATE_W-1:0]     ocur_q;

	logic accept, ld;
	assign in_ready = (st_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign ld       = !ov_q || out_ready;

	// RAM ports
	logic            s_we, x_we, s_re, x_re;
	logic [SAW-1:0]  s_waddr, s_raddr;
	logic [EAW-1:0]  x_waddr, x_raddr;
	logic [SW-1:0]   wslot, wdata, s_rdata, x_rdata, rd;
	logic            clearing;

	assign clearing = (st_q == S_CLEAR);
	assign wslot = {EVENT_BITS'(slot_event), slot_next, slot_stay, ACTION_BITS'(slot_action)};
	assign wdata = clearing ? '0 : wslot;

	always_comb begin
		s_we    = 1'b0;
		x_we    = 1'b0;
		s_waddr = SAW'(int'(slot_state) * SLOTS_PER_STATE + int'(slot_index));
		x_waddr = EAW'(slot_index);
		if (clearing) begin
			s_we    = int'(clr_q) < SDEPTH;
			x_we    = int'(clr_q) < EXT_SLOTS;
			s_waddr = SAW'(clr_q);
			x_waddr = EAW'(clr_q);
		end else if (accept && op_t'(operation) == OP_WRITE) begin
			if (table_select) begin
				x_we = int'(slot_index) < EXT_SLOTS;
			end else begin
				s_we = int'(slot_state) < MAX_STATES && int'(slot_index) < SLOTS_PER_STATE;
			end
		end
	end

	tdfsm_ram #(.WIDTH(SW), .DEPTH(SDEPTH)) u_state_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(wdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);

	tdfsm_ram #(.WIDTH(SW), .DEPTH(EXT_SLOTS)) u_ext_ram (
		.clk(clk), .we(x_we), .waddr(x_waddr), .wdata(wdata),
		.re(x_re), .raddr(x_raddr), .rdata(x_rdata)
	);

	// Scan control: one read issued per cycle, data examined in the next cycle.
	logic [EVENT_BITS-1:0]  rd_ev;
	logic [STATE_W-1:0]     rd_next;
	logic                   rd_stay;
	logic [ACTION_BITS-1:0] rd_act;
	logic                   scan_fin, issue, proc;

	assign rd      = (ph_q == PH_EXT) ? x_rdata : s_rdata;
	assign rd_ev   = rd[SW-1 -: EVENT_BITS];
	assign rd_next = rd[ACTION_BITS+1 +: STATE_W];
	assign rd_stay = rd[ACTION_BITS];
	assign rd_act  = rd[ACTION_BITS-1:0];

	always_comb begin
		if (ph_q == PH_EXT) begin
			len = IW'(EXT_SLOTS);
		end else if (int'(scan_st_q) < MAX_STATES) begin
			len = IW'(SLOTS_PER_STATE);
		end else begin
			len = '0;
		end
	end

	assign scan_fin = (pend_q && rd_ev == EVENT_BITS'(EV_NULL)) || (!pend_q && idx_q == len);
	assign issue    = (st_q == S_SCAN) && !scan_fin && (idx_q < len);
	assign proc     = (st_q == S_SCAN) && pend_q && (rd_ev != EVENT_BITS'(EV_NULL));
	assign x_re     = issue && (ph_q == PH_EXT);
	assign s_re     = issue && (ph_q != PH_EXT);
	assign x_raddr  = EAW'(idx_q);
	assign s_raddr  = SAW'(int'(scan_st_q) * SLOTS_PER_STATE + int'(idx_q));

	// Slot taken by the event, by priority.
	logic [SW-1:0] tk;
	logic          tk_v;
	always_comb begin
		tk_v = 1'b1;
		if (ch_v_q) begin
			tk = ch_q;
		end else if (cd_v_q) begin
			tk = cd_q;
		end else if (xh_v_q) begin
			tk = xh_q;
		end else begin
			tk   = xd_q;
			tk_v = xd_v_q;
		end
	end

	logic [STATE_W-1:0]     tk_next;
	logic                   tk_stay;
	logic [ACTION_BITS-1:0] tk_act, exit_act, entry_act;
	assign tk_next   = tk[ACTION_BITS+1 +: STATE_W];
	assign tk_stay   = tk[ACTION_BITS];
	assign tk_act    = tk[ACTION_BITS-1:0];
	assign exit_act  = cx_v_q ? cx_q : (xx_v_q ? xx_q : '0);
	assign entry_act = nn_v_q ? nn_q : (xn_v_q ? xn_q : '0);

	// Next state and result emission.
	logic               emit;
	kind_t              e_kind;
	logic [ACTION_BITS-1:0] e_act;
	always_comb begin
		st_d   = st_q;
		emit   = 1'b0;
		e_kind = KIND_STATUS;
		e_act  = '0;
		case (st_q)
			S_CLEAR: begin
				if (clr_q == CW'(CLR_N - 1)) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (op_t'(operation) == OP_DELIVER
							&& EVENT_BITS'(event_code) != EVENT_BITS'(EV_NULL)
							&& !(wants_args && !has_args)) begin
						st_d = S_SCAN;
					end else begin
						st_d = S_EMIT_STAT;
					end
				end
			end
			S_SCAN: begin
				if (scan_fin) begin
					case (ph_q)
						PH_EXT:  st_d = S_SCAN;
						PH_CUR:  st_d = S_DECIDE;
						default: st_d = S_EMIT_EXIT;
					endcase
				end
			end
			S_DECIDE: begin
				if (!tk_v) begin
					st_d = S_EMIT_STAT;
				end else if (tk_stay) begin
					st_d = S_EMIT_TRANS;
				end else if ({1'b0, tk_next} >= count_q) begin
					st_d = S_EMIT_STAT;
				end else begin
					st_d = S_SCAN;
				end
			end
			S_EMIT_EXIT: begin
				e_kind = KIND_EXIT;
				e_act  = exit_act;
				if (exit_act == '0) begin
					st_d = S_EMIT_TRANS;
				end else if (ld) begin
					emit = 1'b1;
					st_d = S_EMIT_TRANS;
				end
			end
			S_EMIT_TRANS: begin
				e_kind = KIND_TRANS;
				e_act  = tk_act_q;
				if (tk_act_q == '0 || ld) begin
					emit = tk_act_q != '0;
					st_d = move_q ? S_EMIT_ENTRY : S_EMIT_STAT;
				end
			end
			S_EMIT_ENTRY: begin
				e_kind = KIND_ENTRY;
				e_act  = entry_act;
				if (entry_act == '0 || ld) begin
					emit = entry_act != '0;
					st_d = S_EMIT_STAT;
				end
			end
			S_EMIT_STAT: begin
				if (ld) begin
					emit = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= '0;
			count_q <= 7'd64;
			cur_q   <= '0;
			prev_q  <= '0;
			clr_q   <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			ph_q    <= PH_EXT;
			ov_q    <= 1'b0;
			{xh_v_q, xd_v_q, ch_v_q, cd_v_q} <= '0;
			{xx_v_q, xn_v_q, cx_v_q, nn_v_q} <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_INITIAL: init_q  <= cfg_data[STATE_W-1:0];
					CFG_COUNT:   count_q <= cfg_data;
					default:     ;
				endcase
			end
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			// No read is issued in the cycle a scan finishes, so pend_q drops there.
			if (st_q == S_SCAN) begin
				pend_q <= issue;
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (proc) begin
				case (ph_q)
					PH_EXT: begin
						if (rd_ev == ev_q && !xh_v_q) xh_v_q <= 1'b1;
						if (rd_ev == EVENT_BITS'(EV_DEFAULT)) xd_v_q <= 1'b1;
						if (rd_ev == EVENT_BITS'(EV_EXIT)) xx_v_q <= 1'b1;
						if (rd_ev == EVENT_BITS'(EV_ENTRY)) xn_v_q <= 1'b1;
					end
					PH_CUR: begin
						if (rd_ev == ev_q && !ch_v_q) ch_v_q <= 1'b1;
						if (rd_ev == EVENT_BITS'(EV_DEFAULT)) cd_v_q <= 1'b1;
						if (rd_ev == EVENT_BITS'(EV_EXIT)) cx_v_q <= 1'b1;
					end
					default: begin
						if (rd_ev == EVENT_BITS'(EV_ENTRY)) nn_v_q <= 1'b1;
					end
				endcase
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						pend_q <= 1'b0;
						ph_q   <= PH_EXT;
						{xh_v_q, xd_v_q, ch_v_q, cd_v_q} <= '0;
						{xx_v_q, xn_v_q, cx_v_q, nn_v_q} <= '0;
						case (op_t'(operation))
							OP_RESET:  cur_q <= init_q;
							OP_RETURN: cur_q <= prev_q;
							default:   ;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_fin && ph_q == PH_EXT) begin
						ph_q   <= PH_CUR;
						idx_q  <= '0;
					end
				end
				S_DECIDE: begin
					if (tk_v && tk_stay) begin
						prev_q <= cur_q;
					end else if (tk_v && {1'b0, tk_next} >= count_q) begin
						cur_q <= init_q;
					end else if (tk_v) begin
						ph_q   <= PH_NEW;
						idx_q  <= '0;
						pend_q <= 1'b0;
					end
				end
				S_EMIT_EXIT: begin
					if (st_d == S_EMIT_TRANS) begin
						prev_q <= cur_q;
						cur_q  <= tk_next_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_q      <= EVENT_BITS'(event_code);
			scan_st_q <= cur_q;
			stat_q    <= (op_t'(operation) == OP_DELIVER
					&& EVENT_BITS'(event_code) != EVENT_BITS'(EV_NULL)
					&& wants_args && !has_args) ? ST_NO_ARGS : ST_OK;
		end
		if (st_q == S_SCAN && scan_fin && ph_q == PH_EXT) begin
			scan_st_q <= cur_q;
		end
		if (proc) begin
			case (ph_q)
				PH_EXT: begin
					if (rd_ev == ev_q && !xh_v_q) xh_q <= rd;
					if (rd_ev == EVENT_BITS'(EV_DEFAULT)) xd_q <= rd;
					if (rd_ev == EVENT_BITS'(EV_EXIT)) xx_q <= rd_act;
					if (rd_ev == EVENT_BITS'(EV_ENTRY)) xn_q <= rd_act;
				end
				PH_CUR: begin
					if (rd_ev == ev_q && !ch_v_q) ch_q <= rd;
					if (rd_ev == EVENT_BITS'(EV_DEFAULT)) cd_q <= rd;
					if (rd_ev == EVENT_BITS'(EV_EXIT)) cx_q <= rd_act;
				end
				default: begin
					if (rd_ev == EVENT_BITS'(EV_ENTRY)) nn_q <= rd_act;
				end
			endcase
		end
		if (st_q == S_DECIDE) begin
			tk_next_q <= tk_next;
			tk_act_q  <= tk_act;
			move_q    <= !tk_stay;
			scan_st_q <= tk_next;
			if (!tk_v) begin
				stat_q <= ST_UNKNOWN;
			end else if (!tk_stay && {1'b0, tk_next} >= count_q) begin
				stat_q <= ST_BAD_NXT;
			end
		end
		if (emit) begin
			okind_q <= e_kind;
			oact_q  <= 8'(e_act);
			ostat_q <= (st_q == S_EMIT_STAT) ? stat_q : ST_OK;
			ocur_q  <= cur_q;
			olast_q <= (st_q == S_EMIT_STAT);
		end
	end

	assign out_valid     = ov_q;
	assign result_kind   = okind_q;
	assign action_id     = oact_q;
	assign status        = ostat_q;
	assign current_after = ocur_q;
	assign last          = olast_q;

	// The index never runs past the list being walked.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_SCAN |-> idx_q <= len)
		else $error("scan index beyond list length");

	// A decision is only taken right after a completed scan.
	a_decide_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DECIDE |-> $past(st_q) == S_SCAN)
		else $error("decision without a preceding scan");

	// Only the status result closes an item.
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && olast_q |-> okind_q == KIND_STATUS)
		else $error("final result is not a status result");

	// No item is taken while the tables are being cleared.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |=> !$past(accept))
		else $error("item accepted during clearing pass");

endmodule
